/* hw/rtl/rpn_pkg.sv */
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 5;
    localparam int STATUS_W        = 2;
    localparam int STACK_DEPTH_DEF = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_NEG    = 5'd0;
    localparam logic [OP_W-1:0] OP_LNOT   = 5'd1;
    localparam logic [OP_W-1:0] OP_BNOT   = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV256 = 5'd3;
    localparam logic [OP_W-1:0] OP_MOD256 = 5'd4;
    localparam logic [OP_W-1:0] OP_AND    = 5'd5;
    localparam logic [OP_W-1:0] OP_OR     = 5'd6;
    localparam logic [OP_W-1:0] OP_NOR    = 5'd7;
    localparam logic [OP_W-1:0] OP_XOR    = 5'd8;
    localparam logic [OP_W-1:0] OP_ADD    = 5'd9;
    localparam logic [OP_W-1:0] OP_SUB    = 5'd10;
    localparam logic [OP_W-1:0] OP_MUL    = 5'd11;
    localparam logic [OP_W-1:0] OP_DIV    = 5'd12;
    localparam logic [OP_W-1:0] OP_MOD    = 5'd13;
    localparam logic [OP_W-1:0] OP_SHL    = 5'd14;
    localparam logic [OP_W-1:0] OP_SHR    = 5'd15;
    localparam logic [OP_W-1:0] OP_POW    = 5'd16;
    localparam logic [OP_W-1:0] OP_EQ     = 5'd17;
    localparam logic [OP_W-1:0] OP_LE     = 5'd18;
    localparam logic [OP_W-1:0] OP_GE     = 5'd19;
    localparam logic [OP_W-1:0] OP_NE     = 5'd20;
    localparam logic [OP_W-1:0] OP_LT     = 5'd21;
    localparam logic [OP_W-1:0] OP_GT     = 5'd22;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] STS_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_DIVZ  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CAP_B,
        S_CAP_A,
        S_EXEC,
        S_WAIT,
        S_TOP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;      // latch the incoming word
        logic pop;       // pop one entry (read issued)
        logic cap_b;     // take popped entry as right operand
        logic cap_a;     // take popped entry as left operand
        logic push_val;  // push the word's constant
        logic exec;      // start the operator
        logic push_res;  // push the operator result
        logic top_rd;    // read top of stack
        logic emit;      // load output register, clear stack
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic is_unary;
        logic last;
        logic busy;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/rpn_ram.sv */
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/rpn_ctrl.sv */
module rpn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rpn_pkg::t_sts i_sts,
    output rpn_pkg::t_cmd o_cmd
);

    import rpn_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_push) begin
                    o_cmd.push_val = 1'b1;
                    n_state        = i_sts.last ? S_TOP : S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_sts.is_unary ? S_CAP_A : S_CAP_B;
                end
            end
            S_CAP_B: begin
                // take the right operand and pop the left one
                o_cmd.cap_b = 1'b1;
                o_cmd.pop   = 1'b1;
                n_state     = S_CAP_A;
            end
            S_CAP_A: begin
                o_cmd.cap_a = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.busy) begin
                    o_cmd.push_res = 1'b1;
                    n_state        = i_sts.last ? S_TOP : S_IDLE;
                end
            end
            S_TOP: begin
                o_cmd.top_rd = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/rpn_dp.sv */
module rpn_dp #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rpn_pkg::t_cmd                       i_cmd,
    output rpn_pkg::t_sts                       o_sts,
    input  logic                                i_action,
    input  logic [rpn_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [rpn_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0]   o_result,
    output logic [rpn_pkg::STATUS_W-1:0]        o_status
);

    import rpn_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    // token
    logic              r_action;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_value;
    logic              r_last;

    // stack control
    logic [SP_W-1:0]     r_sp;
    logic [SP_W-1:0]     n_sp;
    logic [SP_W-1:0]     w_sp_dec;
    logic                w_empty;
    logic                w_full;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                w_err;
    logic [STATUS_W-1:0] w_err_code;
    logic                r_pop_ok;

    // memory port
    logic              w_wr_en;
    logic [DATA_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [DATA_W-1:0] w_rd_data;

    // operands and result
    logic [DATA_W-1:0] r_opa;
    logic [DATA_W-1:0] r_opb;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] w_alu;
    logic [DATA_W-1:0] w_mag_a;
    logic [DATA_W-1:0] w_mag_b;
    logic [DATA_W-1:0] w_d256;
    logic [DATA_W-1:0] w_m256;
    logic              w_lt_ab;
    logic              w_lt_ba;
    logic              w_is_iter;
    logic              w_b_zero;

    // shared iterative unit: restoring divider or square-and-multiply
    logic              r_busy;
    logic              r_fix;
    logic              r_is_div;
    logic [4:0]        r_cnt;
    logic [DATA_W-1:0] r_wa;
    logic [DATA_W-1:0] r_wb;
    logic [DATA_W-1:0] r_wc;
    logic              r_sa;
    logic              r_sb;
    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_diff;
    logic              w_ge;
    logic [DATA_W-1:0] w_mul_acc;
    logic [DATA_W-1:0] w_mul_sq;
    logic [DATA_W-1:0] w_exp_nxt;
    logic [DATA_W-1:0] w_fix_val;

    // output register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_result;
    logic [STATUS_W-1:0] r_out_status;
    logic                w_out_free;

    assign w_sp_dec = r_sp - 1'b1;
    assign w_empty  = (r_sp == '0);
    assign w_full   = (r_sp == SP_W'(STACK_DEPTH));

    assign w_wr_en   = (i_cmd.push_val || i_cmd.push_res) && !w_full;
    assign w_wr_data = i_cmd.push_val ? r_value : r_res;
    assign w_rd_en   = (i_cmd.pop || i_cmd.top_rd) && !w_empty;

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_sp[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_sp_dec[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // ALU
    assign w_mag_a = r_opa[DATA_W-1] ? (~r_opa + 1'b1) : r_opa;
    assign w_mag_b = r_opb[DATA_W-1] ? (~r_opb + 1'b1) : r_opb;
    assign w_d256  = {8'd0, w_mag_a[DATA_W-1:8]};
    assign w_m256  = {24'd0, w_mag_a[7:0]};
    assign w_lt_ab = $signed(r_opa) < $signed(r_opb);
    assign w_lt_ba = $signed(r_opb) < $signed(r_opa);
    assign w_b_zero = (r_opb == '0);
    assign w_is_iter = (r_op == OP_MUL) || (r_op == OP_DIV) ||
                       (r_op == OP_MOD) || (r_op == OP_POW);

    always_comb begin
        case (r_op)
            OP_NEG:    w_alu = ~r_opa + 1'b1;
            OP_LNOT:   w_alu = {31'd0, (r_opa == '0)};
            OP_BNOT:   w_alu = ~r_opa;
            OP_DIV256: w_alu = r_opa[DATA_W-1] ? (~w_d256 + 1'b1) : w_d256;
            OP_MOD256: w_alu = r_opa[DATA_W-1] ? (~w_m256 + 1'b1) : w_m256;
            OP_AND:    w_alu = r_opa & r_opb;
            OP_OR:     w_alu = r_opa | r_opb;
            OP_NOR:    w_alu = ~(r_opa | r_opb);
            OP_XOR:    w_alu = r_opa ^ r_opb;
            OP_ADD:    w_alu = r_opa + r_opb;
            OP_SUB:    w_alu = r_opa - r_opb;
            OP_SHL:    w_alu = r_opa << r_opb[4:0];
            OP_SHR:    w_alu = r_opa >> r_opb[4:0];
            OP_EQ:     w_alu = {31'd0, (r_opa == r_opb)};
            OP_LE:     w_alu = {31'd0, !w_lt_ba};
            OP_GE:     w_alu = {31'd0, !w_lt_ab};
            OP_NE:     w_alu = {31'd0, (r_opa != r_opb)};
            OP_LT:     w_alu = {31'd0, w_lt_ab};
            OP_GT:     w_alu = {31'd0, w_lt_ba};
            default:   w_alu = '0;
        endcase
    end

    // iterative step logic
    assign w_rem_sh  = {r_wb, r_wa[DATA_W-1]};
    assign w_diff    = w_rem_sh - {1'b0, r_wc};
    assign w_ge      = !w_diff[DATA_W];
    assign w_mul_acc = r_wa * r_wb;
    assign w_mul_sq  = r_wb * r_wb;
    assign w_exp_nxt = r_wc >> 1;

    always_comb begin
        if (!r_is_div) begin
            w_fix_val = r_wa;
        end else if (r_op == OP_DIV) begin
            w_fix_val = (r_sa ^ r_sb) ? (~r_wa + 1'b1) : r_wa;
        end else begin
            w_fix_val = r_sa ? (~r_wb + 1'b1) : r_wb;
        end
    end

    // stack pointer and sticky status
    always_comb begin
        n_sp       = r_sp;
        w_err      = 1'b0;
        w_err_code = STS_OK;
        if (i_cmd.pop) begin
            if (w_empty) begin
                w_err      = 1'b1;
                w_err_code = STS_UNDER;
            end else begin
                n_sp = w_sp_dec;
            end
        end
        if (i_cmd.push_val || i_cmd.push_res) begin
            if (w_full) begin
                w_err      = 1'b1;
                w_err_code = STS_OVER;
            end else begin
                n_sp = r_sp + 1'b1;
            end
        end
        if (i_cmd.exec && (r_op == OP_DIV || r_op == OP_MOD) && w_b_zero) begin
            w_err      = 1'b1;
            w_err_code = STS_DIVZ;
        end
        n_status = r_status;
        if (w_err && r_status == STS_OK) begin
            n_status = w_err_code;
        end
        if (i_cmd.emit) begin
            n_sp     = '0;
            n_status = STS_OK;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_status    <= STS_OK;
            r_busy      <= 1'b0;
            r_fix       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp     <= n_sp;
            r_status <= n_status;
            r_fix    <= 1'b0;
            if (i_cmd.exec) begin
                if (r_op == OP_MUL) begin
                    r_busy <= 1'b1;
                end else if (r_op == OP_POW) begin
                    r_busy <= !(r_opb[DATA_W-1] || w_b_zero);
                end else if (r_op == OP_DIV || r_op == OP_MOD) begin
                    r_busy <= !w_b_zero;
                end
            end else if (r_busy) begin
                if (r_is_div ? (r_cnt == '0) : (w_exp_nxt == '0)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_op     <= i_opcode;
            r_value  <= i_value;
            r_last   <= i_last;
        end
        if (i_cmd.pop) begin
            r_pop_ok <= !w_empty;
        end
        if (i_cmd.cap_b) begin
            r_opb <= r_pop_ok ? w_rd_data : '0;
        end
        if (i_cmd.cap_a) begin
            r_opa <= r_pop_ok ? w_rd_data : '0;
        end
        if (i_cmd.exec) begin
            r_sa <= r_opa[DATA_W-1];
            r_sb <= r_opb[DATA_W-1];
            if (r_op == OP_MUL) begin
                // one multiply step: acc = a, base = b, exponent one
                r_is_div <= 1'b0;
                r_wa     <= r_opa;
                r_wb     <= r_opb;
                r_wc     <= DATA_W'(1);
            end else if (r_op == OP_POW) begin
                r_is_div <= 1'b0;
                r_wa     <= DATA_W'(1);
                r_wb     <= r_opa;
                r_wc     <= r_opb;
                r_res    <= DATA_W'(1);
            end else if (r_op == OP_DIV || r_op == OP_MOD) begin
                r_is_div <= 1'b1;
                r_wa     <= w_mag_a;
                r_wb     <= '0;
                r_wc     <= w_mag_b;
                r_cnt    <= 5'd31;
                r_res    <= '0;
            end else begin
                r_res <= w_alu;
            end
        end else if (r_busy) begin
            if (r_is_div) begin
                r_wa  <= {r_wa[DATA_W-2:0], w_ge};
                r_wb  <= w_ge ? w_diff[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
                r_cnt <= r_cnt - 1'b1;
            end else begin
                if (r_wc[0]) begin
                    r_wa <= w_mul_acc;
                end
                r_wb <= w_mul_sq;
                r_wc <= w_exp_nxt;
            end
        end
        if (r_fix) begin
            r_res <= w_fix_val;
        end
        if (i_cmd.emit) begin
            r_out_result <= w_empty ? '0 : w_rd_data;
            r_out_status <= r_status;
        end
    end

    assign o_sts.is_push  = !r_action;
    assign o_sts.is_unary = (r_op <= OP_MOD256);
    assign o_sts.last     = r_last;
    assign o_sts.busy     = r_busy || r_fix || (i_cmd.exec && w_is_iter);
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_result;
    assign o_status    = r_out_status;

endmodule

/* hw/rtl/postfix_expression_evaluator_top.sv */
// Postfix expression evaluator on a bounded operand stack.
//
// Input channel (i_in_valid / o_in_stall): one token word per handshake.
// A word either pushes i_value or applies the operator in i_opcode to the
// top one or two stack entries. i_last marks the end of an expression.
// Output channel (o_out_valid / i_out_stall): one word per expression,
// carrying the top of stack (0 when empty) and the first error seen.
//
// One token is worked at a time; the input stalls until it is done.
// Push and the combinational ALU operators need no iteration. Multiply
// runs one square-and-multiply step. Power skips the iteration for an
// exponent of zero or less, else it runs one step per exponent bit.
// Divide and modulo use the bit-serial restoring divider; a zero divisor
// skips the divider.
// A last token then reads the top of stack and waits while the output
// register stays stalled; the next token is taken only after the result
// has moved into the output register.
// Reset empties the stack and clears the status; stack entries need no
// clearing since an entry is read only after it has been written.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [rpn_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [rpn_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0]   o_result,
    output logic [rpn_pkg::STATUS_W-1:0]        o_status
);

    import rpn_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_action    (i_action),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result),
        .o_status    (o_status)
    );

    // an accepted word is worked before the next one is taken
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a token");

    // never push a result or emit while the iterative unit is still running
    a_no_early_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.push_res || w_cmd.emit) |-> !w_sts.busy)
        else $error("push or emit while busy");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.push_val, w_cmd.exec, w_cmd.push_res,
                  w_cmd.top_rd, w_cmd.emit}))
        else $error("conflicting datapath commands");

    // a result word appears only from an emit
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.emit))
        else $error("output valid without emit");

endmodule
